### design/hsrgb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// hsrgb_pkg
// Shared types and constants for the RGB-split shutter effect core.
// ============================================================================
package hsrgb_pkg;

    // Default sizes
    localparam int PIXELS_DEF    = 4096;
    localparam int MAX_DELAY_DEF = 16;

    // Field widths
    localparam int PIX_W      = 32;
    localparam int DELAY_W    = 5;
    localparam int FP_W       = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // Register reset values
    localparam int DELAY_RESET = 1;
    localparam int FP_RESET    = 4096;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DELAY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MODE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME = 2'd2;

    // ARGB lane masks
    localparam logic [PIX_W-1:0] MASK_A = 32'hFF00_0000;
    localparam logic [PIX_W-1:0] MASK_R = 32'h00FF_0000;
    localparam logic [PIX_W-1:0] MASK_G = 32'h0000_FF00;
    localparam logic [PIX_W-1:0] MASK_B = 32'h0000_00FF;
    localparam logic [PIX_W-1:0] KEEP_R = 32'hFF00_FFFF;
    localparam logic [PIX_W-1:0] KEEP_G = 32'hFFFF_00FF;
    localparam logic [PIX_W-1:0] KEEP_B = 32'hFFFF_FF00;

    // Channel overwritten in simple mode
    typedef enum logic [1:0] {
        CH_RED   = 2'd0,
        CH_GREEN = 2'd1,
        CH_BLUE  = 2'd2
    } t_chan;

    // Frame sequencer status seen by the datapath
    typedef struct packed {
        logic  simple;  // channel-overwrite mode
        logic  first;   // no frame completed yet
        t_chan chan;    // channel to overwrite
    } t_seq_ctl;

endpackage
`default_nettype wire

### design/harris_shutter_rgb_split_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// harris_shutter_rgb_split_core
// RGB-split shutter effect on an ARGB pixel stream, one pixel out per pixel.
// ============================================================================
// Pixels arrive in raster order, frame_pixels to a frame, and the core takes
// one pixel per clock when o_in_stall is low and returns one pixel per pixel,
// in order, through stage 1 and the output register. The rate is set by the
// history RAM, which can do one write and two registered reads each cycle.
// In smooth mode (simple_mode = 0) every frame goes into a ring of
// 2*delay+1 frame slots; red comes from the frame 2*delay back, green from
// delay back, blue and alpha from the current pixel, with both offsets
// clamped to the frames seen since the last counter clear. In simple mode
// (simple_mode = 1) the first frame is copied into a composite frame, and
// each later frame overwrites one channel of it, rotating R, G, B every
// delay frames; the composite is the output. The composite lives in slot 0
// of the same RAM. Writing delay_frames, simple_mode or frame_pixels with a
// new effective value restarts the frame sequence; stored pixels are kept
// but never read before being rewritten, so the RAM needs no clearing pass
// after reset. Write registers only while the core is idle.
// Register map: 0 delay_frames (0 acts as 1, clamped to MAX_DELAY),
// 1 simple_mode, 2 frame_pixels (0 acts as 1, clamped to PIXELS).
// ============================================================================
module harris_shutter_rgb_split_core #(
    parameter int MAX_DELAY = hsrgb_pkg::MAX_DELAY_DEF,
    parameter int PIXELS    = hsrgb_pkg::PIXELS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // configuration write channel
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [hsrgb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [hsrgb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // pixel input
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic [hsrgb_pkg::PIX_W-1:0]      i_pixel_in,
    // pixel output
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic      [hsrgb_pkg::PIX_W-1:0]      o_pixel_out
);

    localparam int PIX_W      = hsrgb_pkg::PIX_W;
    localparam int RING_SLOTS = 2 * MAX_DELAY + 1;
    localparam int SLOT_W     = $clog2(RING_SLOTS);
    localparam int IDX_W      = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam int ADDR_W     = SLOT_W + IDX_W;
    // Rows are padded to a power of two so an address is {slot, index}
    localparam int HIST_DEPTH = RING_SLOTS * (2 ** IDX_W);

    hsrgb_pkg::t_seq_ctl ctl;
    logic [SLOT_W-1:0]   head, g_slot, r_slot;
    logic [IDX_W-1:0]    idx;

    logic                accept;
    logic                s1_move;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr, ram_raddr0, ram_raddr1;
    logic [PIX_W-1:0]    ram_wdata, ram_rdata0, ram_rdata1;

    // stage 1: RAM read data arrives here
    logic                r_s1_valid;
    logic [PIX_W-1:0]    r_s1_src;
    logic [IDX_W-1:0]    r_s1_idx;
    logic                r_s1_first;
    logic                r_s1_simple;
    hsrgb_pkg::t_chan    r_s1_chan;
    logic                r_s1_fwd;
    logic [PIX_W-1:0]    r_fwd_data;

    logic [PIX_W-1:0]    comp_old;
    logic [PIX_W-1:0]    s1_res;

    // output register
    logic                r_out_valid;
    logic [PIX_W-1:0]    r_out_pixel;

    assign o_cfg_ready = 1'b1;

    hsrgb_seq #(
        .MAX_DELAY (MAX_DELAY),
        .PIXELS    (PIXELS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid & o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_adv       (accept),
        .o_ctl       (ctl),
        .o_head      (head),
        .o_g_slot    (g_slot),
        .o_r_slot    (r_slot),
        .o_idx       (idx)
    );

    // Handshake: stage 1 frees when it moves into the output register
    assign s1_move    = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_move;
    assign accept     = i_in_valid && !o_in_stall;

    // Smooth mode writes the incoming pixel at accept; simple mode writes
    // the merged composite pixel as it leaves stage 1.
    assign ram_raddr0 = ctl.simple ? {SLOT_W'(0), idx} : {g_slot, idx};
    assign ram_raddr1 = {r_slot, idx};
    assign ram_we     = ctl.simple ? s1_move : accept;
    assign ram_waddr  = ctl.simple ? {SLOT_W'(0), r_s1_idx} : {head, idx};
    assign ram_wdata  = ctl.simple ? s1_res : i_pixel_in;

    hsrgb_ram #(
        .WIDTH (PIX_W),
        .DEPTH (HIST_DEPTH)
    ) u_hist (
        .i_clk    (i_clk),
        .i_we     (ram_we),
        .i_waddr  (ram_waddr),
        .i_wdata  (ram_wdata),
        .i_re     (accept),
        .i_raddr0 (ram_raddr0),
        .i_raddr1 (ram_raddr1),
        .o_rdata0 (ram_rdata0),
        .o_rdata1 (ram_rdata1)
    );

    // Stage 1 capture. With a one-pixel frame the composite entry read now
    // is the one stage 1 writes at this same edge, so its value is forwarded.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_src    <= i_pixel_in;
            r_s1_idx    <= idx;
            r_s1_first  <= ctl.first;
            r_s1_simple <= ctl.simple;
            r_s1_chan   <= ctl.chan;
            r_s1_fwd    <= ctl.simple && r_s1_valid && (r_s1_idx == idx);
            r_fwd_data  <= s1_res;
        end
    end

    assign comp_old = r_s1_fwd ? r_fwd_data : ram_rdata0;

    // Before the first frame completes both modes pass the pixel through:
    // the composite is being filled, and the ring reads would hit the slot
    // being written.
    always_comb begin
        if (r_s1_first) begin
            s1_res = r_s1_src;
        end else if (r_s1_simple) begin
            case (r_s1_chan)
                hsrgb_pkg::CH_RED:
                    s1_res = (comp_old & hsrgb_pkg::KEEP_R) | (r_s1_src & hsrgb_pkg::MASK_R);
                hsrgb_pkg::CH_GREEN:
                    s1_res = (comp_old & hsrgb_pkg::KEEP_G) | (r_s1_src & hsrgb_pkg::MASK_G);
                default:
                    s1_res = (comp_old & hsrgb_pkg::KEEP_B) | (r_s1_src & hsrgb_pkg::MASK_B);
            endcase
        end else begin
            s1_res = (ram_rdata1 & hsrgb_pkg::MASK_R)
                   | (ram_rdata0 & hsrgb_pkg::MASK_G)
                   | (r_s1_src & (hsrgb_pkg::MASK_A | hsrgb_pkg::MASK_B));
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_pixel <= s1_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pixel_out = r_out_pixel;

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_move) |=> (r_s1_valid && $stable(r_s1_src)))
        else $error("stage 1 beat lost while blocked");

    a_s1_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_s1_valid) |-> s1_move)
        else $error("stage 1 overwritten before moving on");

    a_fwd_simple: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_fwd) |-> r_s1_simple)
        else $error("composite forward outside simple mode");

    a_mode_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> (r_s1_simple == ctl.simple))
        else $error("mode changed with a beat in flight");

endmodule
`default_nettype wire

### design/hsrgb_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// hsrgb_ram
// Generic RAM: one write port, two read ports, registered read data.
// ============================================================================
module hsrgb_ram #(
    parameter  int WIDTH  = 32,
    parameter  int DEPTH  = 1024,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr0,
    input  wire logic [ADDR_W-1:0] i_raddr1,
    output logic      [WIDTH-1:0]  o_rdata0,
    output logic      [WIDTH-1:0]  o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata0;
    logic [WIDTH-1:0] r_rdata1;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata0 <= r_mem[i_raddr0];
            r_rdata1 <= r_mem[i_raddr1];
        end
    end

    assign o_rdata0 = r_rdata0;
    assign o_rdata1 = r_rdata1;

endmodule
`default_nettype wire

### design/hsrgb_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// hsrgb_seq
// Configuration registers and frame sequencing: pixel position, ring head,
// frame count, channel rotation and the history slots to read.
// ============================================================================
module hsrgb_seq #(
    parameter  int MAX_DELAY  = hsrgb_pkg::MAX_DELAY_DEF,
    parameter  int PIXELS     = hsrgb_pkg::PIXELS_DEF,
    localparam int DLY_W      = $clog2(MAX_DELAY + 1),
    localparam int RING_SLOTS = 2 * MAX_DELAY + 1,
    localparam int SLOT_W     = $clog2(RING_SLOTS),
    localparam int IDX_W      = (PIXELS > 1) ? $clog2(PIXELS) : 1
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [hsrgb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [hsrgb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                             i_adv,
    output hsrgb_pkg::t_seq_ctl                   o_ctl,
    output logic      [SLOT_W-1:0]                o_head,
    output logic      [SLOT_W-1:0]                o_g_slot,
    output logic      [SLOT_W-1:0]                o_r_slot,
    output logic      [IDX_W-1:0]                 o_idx
);

    localparam int FP_W     = hsrgb_pkg::FP_W;
    localparam int FP_RST32 = (PIXELS < hsrgb_pkg::FP_RESET) ? PIXELS : hsrgb_pkg::FP_RESET;

    logic [DLY_W-1:0]       r_delay, n_delay;
    logic                   r_simple, n_simple;
    logic [FP_W-1:0]        r_fpix, n_fpix;
    logic [SLOT_W-1:0]      r_fcnt, n_fcnt;
    logic [SLOT_W-1:0]      r_head, n_head;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic [DLY_W-1:0]       r_phase, n_phase;
    hsrgb_pkg::t_chan       r_chan, n_chan, chan_next;

    logic [31:0]            cfg_d32, cfg_f32;
    logic [DLY_W-1:0]       cfg_delay;
    logic [FP_W-1:0]        cfg_fpix;
    logic                   cfg_clear;
    logic                   last;
    logic [SLOT_W-1:0]      twice_d;
    logic [SLOT_W-1:0]      off_g;
    logic [SLOT_W:0]        len_ext;
    logic [SLOT_W:0]        g_wrap, r_wrap;

    // Clamp written values into the supported range
    always_comb begin
        cfg_d32 = 32'(i_cfg_data[hsrgb_pkg::DELAY_W-1:0]);
        if (cfg_d32 == 32'd0) begin
            cfg_d32 = 32'd1;
        end else if (cfg_d32 > 32'(MAX_DELAY)) begin
            cfg_d32 = 32'(MAX_DELAY);
        end
        cfg_f32 = 32'(i_cfg_data[FP_W-1:0]);
        if (cfg_f32 == 32'd0) begin
            cfg_f32 = 32'd1;
        end else if (cfg_f32 > 32'(PIXELS)) begin
            cfg_f32 = 32'(PIXELS);
        end
        cfg_delay = DLY_W'(cfg_d32);
        cfg_fpix  = FP_W'(cfg_f32);
    end

    assign twice_d = SLOT_W'(32'd2 * 32'(r_delay));
    assign last    = (32'(r_idx) + 32'd1) >= 32'(r_fpix);

    always_comb begin
        case (r_chan)
            hsrgb_pkg::CH_RED:   chan_next = hsrgb_pkg::CH_GREEN;
            hsrgb_pkg::CH_GREEN: chan_next = hsrgb_pkg::CH_BLUE;
            default:             chan_next = hsrgb_pkg::CH_RED;
        endcase
    end

    always_comb begin
        n_delay   = r_delay;
        n_simple  = r_simple;
        n_fpix    = r_fpix;
        n_fcnt    = r_fcnt;
        n_head    = r_head;
        n_idx     = r_idx;
        n_phase   = r_phase;
        n_chan    = r_chan;
        cfg_clear = 1'b0;

        if (i_adv) begin
            if (!last) begin
                n_idx = r_idx + 1'b1;
            end else begin
                n_idx = '0;
                if (r_simple) begin
                    if (r_fcnt == '0) begin
                        n_fcnt = SLOT_W'(1);
                        if (r_delay == DLY_W'(1)) begin
                            n_phase = '0;
                            n_chan  = hsrgb_pkg::CH_GREEN;
                        end else begin
                            n_phase = DLY_W'(1);
                            n_chan  = hsrgb_pkg::CH_RED;
                        end
                    end else if ((32'(r_phase) + 32'd1) >= 32'(r_delay)) begin
                        n_phase = '0;
                        n_chan  = chan_next;
                    end else begin
                        n_phase = r_phase + 1'b1;
                    end
                end else begin
                    n_head = (r_head == twice_d) ? '0 : r_head + 1'b1;
                    if (r_fcnt < twice_d) begin
                        n_fcnt = r_fcnt + 1'b1;
                    end
                end
            end
        end

        if (i_cfg_we) begin
            case (i_cfg_index)
                hsrgb_pkg::REG_DELAY: begin
                    n_delay   = cfg_delay;
                    cfg_clear = (cfg_delay != r_delay);
                end
                hsrgb_pkg::REG_MODE: begin
                    n_simple  = i_cfg_data[0];
                    cfg_clear = (i_cfg_data[0] != r_simple);
                end
                hsrgb_pkg::REG_FRAME: begin
                    n_fpix    = cfg_fpix;
                    cfg_clear = (cfg_fpix != r_fpix);
                end
                default: begin
                    cfg_clear = 1'b0;
                end
            endcase
        end

        if (cfg_clear) begin
            n_fcnt  = '0;
            n_head  = '0;
            n_idx   = '0;
            n_phase = '0;
            n_chan  = hsrgb_pkg::CH_RED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay  <= DLY_W'(hsrgb_pkg::DELAY_RESET);
            r_simple <= 1'b0;
            r_fpix   <= FP_W'(FP_RST32);
            r_fcnt   <= '0;
            r_head   <= '0;
            r_idx    <= '0;
            r_phase  <= '0;
            r_chan   <= hsrgb_pkg::CH_RED;
        end else begin
            r_delay  <= n_delay;
            r_simple <= n_simple;
            r_fpix   <= n_fpix;
            r_fcnt   <= n_fcnt;
            r_head   <= n_head;
            r_idx    <= n_idx;
            r_phase  <= n_phase;
            r_chan   <= n_chan;
        end
    end

    // Read slots: green delay frames back, red 2*delay back, both clamped
    // to the frames seen (frame count never exceeds 2*delay)
    assign off_g   = (SLOT_W'(r_delay) < r_fcnt) ? SLOT_W'(r_delay) : r_fcnt;
    assign len_ext = (SLOT_W + 1)'(twice_d) + 1'b1;
    assign g_wrap  = {1'b0, r_head} + len_ext - {1'b0, off_g};
    assign r_wrap  = {1'b0, r_head} + len_ext - {1'b0, r_fcnt};

    assign o_g_slot = (r_head >= off_g)  ? r_head - off_g  : SLOT_W'(g_wrap);
    assign o_r_slot = (r_head >= r_fcnt) ? r_head - r_fcnt : SLOT_W'(r_wrap);
    assign o_head   = r_head;
    assign o_idx    = r_idx;

    assign o_ctl.simple = r_simple;
    assign o_ctl.first  = (r_fcnt == '0);
    assign o_ctl.chan   = r_chan;

    a_fcnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fcnt <= twice_d)
        else $error("frame count beyond 2*delay");

    a_head_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= twice_d)
        else $error("ring head outside the active ring");

    a_phase_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_simple && (r_fcnt != '0)) |-> (r_phase < r_delay))
        else $error("delay phase not below delay");

endmodule
`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for the RGB-split shutter core.
// ============================================================================
// A queue of pending operations (pixel beats and register writes) is filled
// at time zero. A clocked driver plays it out on the pixel and register
// channels. A clocked monitor predicts each accepted pixel beat and compares
// it with the oldest outstanding prediction when the matching output beat is
// taken. The prediction keeps its own frame ring, composite frame, sequence
// counters and register copies.
// Register writes are issued only once every predicted beat has come back
// and the pipe has had a few quiet cycles.
// Stimulus runs in two parts. A short directed part covers reset defaults,
// clamping of zero and oversized register values, writes that repeat the
// current value, the unused register index, offset clamping while the ring
// fills, and the channel rotation in simple mode, including the jump after
// the first frame. A long random part follows, built from frame sequences
// with random content, capped at about RAND_PIX pixel beats.
// ============================================================================
module tb_top;
    import hsrgb_pkg::*;

    localparam int N_PIX    = PIXELS_DEF;
    localparam int N_DLY    = MAX_DELAY_DEF;
    localparam int N_SLOT   = 2 * N_DLY + 1;
    localparam int RAND_PIX = 500;      // random pixel beats, roughly
    localparam int TAIL_OPS = 100;      // final stretch runs with no idling
    localparam int SETTLE   = 4;        // quiet cycles before a register write

    // Index 3 is not mapped in the core; writes there must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef enum logic {OP_PIXEL, OP_REG} t_op_kind;

    typedef struct packed {
        t_op_kind               kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  data;
        logic [PIX_W-1:0]       pix;
    } t_op;

    // ------------------------------------------------------------------------
    // DUT ports. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;
    logic                   i_in_valid  = 1'b0;
    logic [PIX_W-1:0]       i_pixel_in  = '0;
    logic                   i_out_stall = 1'b0;
    logic                   o_cfg_ready;
    logic                   o_in_stall;
    logic                   o_out_valid;
    logic [PIX_W-1:0]       o_pixel_out;

    harris_shutter_rgb_split_core #(
        .MAX_DELAY (N_DLY),
        .PIXELS    (N_PIX)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_pixel_in  (i_pixel_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_pixel_out (o_pixel_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Shared bench state
    // ------------------------------------------------------------------------
    t_op              stim_q[$];        // pending operations, filled at time 0
    logic [PIX_W-1:0] expected_pixels[$];
    int unsigned      pix_in_flight = 0;  // predictions not yet matched (NBA)
    logic             tail          = 1'b0;
    logic             drv_done      = 1'b0;
    int unsigned      err_cnt       = 0;

    // ------------------------------------------------------------------------
    // Predictor state: frame ring, composite frame, counters, registers
    // ------------------------------------------------------------------------
    logic [PIX_W-1:0] ring_mem [N_SLOT*N_PIX];
    logic [PIX_W-1:0] comp_mem [N_PIX];
    int unsigned      seen_frames;
    int unsigned      head_slot;
    int unsigned      pix_pos;
    int unsigned      rot_phase;
    t_chan            rot_chan;
    int unsigned      cur_delay = DELAY_RESET;
    logic             cur_simple = 1'b0;
    int unsigned      cur_fpix  = FP_RESET;

    function automatic void restart_sequence();
        seen_frames = 0;
        head_slot   = 0;
        pix_pos     = 0;
        rot_phase   = 0;
        rot_chan    = CH_RED;
    endfunction

    // Register write as the core sees it: clamp, then restart only on a change.
    function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] data);
        int unsigned v;
        case (idx)
            REG_DELAY: begin
                v = 32'(data[DELAY_W-1:0]);
                if (v < 1) v = 1;
                if (v > N_DLY) v = N_DLY;
                if (v != cur_delay) begin
                    cur_delay = v;
                    restart_sequence();
                end
            end
            REG_MODE: begin
                if (data[0] != cur_simple) begin
                    cur_simple = data[0];
                    restart_sequence();
                end
            end
            REG_FRAME: begin
                v = 32'(data[FP_W-1:0]);
                if (v < 1) v = 1;
                if (v > N_PIX) v = N_PIX;
                if (v != cur_fpix) begin
                    cur_fpix = v;
                    restart_sequence();
                end
            end
            default: ;
        endcase
    endfunction

    // Output pixel for one input pixel; advances position and frame counters.
    function automatic logic [PIX_W-1:0] shutter_pixel(input logic [PIX_W-1:0] src);
        int unsigned      pos;
        int unsigned      ring;
        int unsigned      hd;
        int unsigned      off_g;
        int unsigned      off_r;
        logic [PIX_W-1:0] g_pix;
        logic [PIX_W-1:0] r_pix;
        logic [PIX_W-1:0] res;
        pos = (pix_pos >= cur_fpix) ? 0 : pix_pos;
        ring = 2 * cur_delay + 1;
        if (cur_simple) begin
            // first frame is copied whole, later ones overwrite one lane
            if (seen_frames == 0) begin
                comp_mem[pos] = src;
            end else begin
                case (rot_chan)
                    CH_RED:   comp_mem[pos] = (comp_mem[pos] & KEEP_R) | (src & MASK_R);
                    CH_GREEN: comp_mem[pos] = (comp_mem[pos] & KEEP_G) | (src & MASK_G);
                    default:  comp_mem[pos] = (comp_mem[pos] & KEEP_B) | (src & MASK_B);
                endcase
            end
            res = comp_mem[pos];
        end else begin
            // offsets clamp to frames seen, so unwritten slots are never read
            hd    = head_slot % ring;
            off_g = (cur_delay < seen_frames) ? cur_delay : seen_frames;
            off_r = (2 * cur_delay < seen_frames) ? 2 * cur_delay : seen_frames;
            ring_mem[hd*N_PIX + pos] = src;
            g_pix = ring_mem[((hd + ring - off_g) % ring)*N_PIX + pos];
            r_pix = ring_mem[((hd + ring - off_r) % ring)*N_PIX + pos];
            res = (r_pix & MASK_R) | (g_pix & MASK_G) | (src & (MASK_A | MASK_B));
        end
        pos++;
        if (pos < cur_fpix) begin
            pix_pos = pos;
        end else begin
            pix_pos = 0;
            if (!cur_simple) begin
                head_slot = (head_slot + 1) % ring;
                if (seen_frames < 2 * cur_delay) seen_frames++;
            end else if (seen_frames == 0) begin
                // count goes straight to 1 after the first frame
                seen_frames = 1;
                rot_phase   = (cur_delay == 1) ? 0 : 1;
                rot_chan    = (cur_delay == 1) ? CH_GREEN : CH_RED;
            end else begin
                rot_phase++;
                if (rot_phase >= cur_delay) begin
                    rot_phase = 0;
                    case (rot_chan)
                        CH_RED:   rot_chan = CH_GREEN;
                        CH_GREEN: rot_chan = CH_BLUE;
                        default:  rot_chan = CH_RED;
                    endcase
                end
            end
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: plays out stim_q. A pixel beat holds until taken; a register
    // write waits until the pipe is empty and has stayed quiet (see SETTLE).
    // ------------------------------------------------------------------------
    int unsigned in_gap   = 0;
    int unsigned in_calm  = 0;
    int unsigned reg_wait = 0;

    always @(posedge i_clk) begin : drive_proc
        t_op                   op;
        logic                  pix_hold;
        logic                  reg_hold;
        logic                  nxt_in_valid;
        logic                  nxt_cfg_valid;
        logic [PIX_W-1:0]      nxt_pix;
        logic [CFG_IDX_W-1:0]  nxt_idx;
        logic [CFG_DATA_W-1:0] nxt_data;
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            i_cfg_valid <= 1'b0;
            in_gap   = 0;
            reg_wait = 0;
        end else begin
            pix_hold      = i_in_valid && o_in_stall;
            reg_hold      = i_cfg_valid && !o_cfg_ready;
            nxt_in_valid  = pix_hold;
            nxt_cfg_valid = reg_hold;
            nxt_pix       = i_pixel_in;
            nxt_idx       = i_cfg_index;
            nxt_data      = i_cfg_data;

            // after each taken beat, maybe open a gap or a calm stretch
            if (i_in_valid && !o_in_stall && stim_q.size() >= TAIL_OPS) begin
                if (in_calm > 0)
                    in_calm--;
                else if ($urandom_range(0, 39) == 0)
                    in_calm = $urandom_range(16, 64);
                else if ($urandom_range(0, 4) == 0)
                    in_gap = $urandom_range(1, 15);
            end

            if (!pix_hold && !reg_hold && stim_q.size() > 0) begin
                if (stim_q[0].kind == OP_REG) begin
                    if (pix_in_flight == 0 && !i_in_valid)
                        reg_wait++;
                    else
                        reg_wait = 0;
                    if (reg_wait >= SETTLE) begin
                        op = stim_q.pop_front();
                        nxt_cfg_valid = 1'b1;
                        nxt_idx       = op.idx;
                        nxt_data      = op.data;
                    end
                end else if (in_gap > 0 && stim_q.size() >= TAIL_OPS) begin
                    in_gap--;
                end else begin
                    op = stim_q.pop_front();
                    nxt_in_valid = 1'b1;
                    nxt_pix      = op.pix;
                end
            end

            i_in_valid  <= nxt_in_valid;
            i_pixel_in  <= nxt_pix;
            i_cfg_valid <= nxt_cfg_valid;
            i_cfg_index <= nxt_idx;
            i_cfg_data  <= nxt_data;
            tail        <= (stim_q.size() < TAIL_OPS);
            drv_done    <= (stim_q.size() == 0) && !nxt_in_valid && !nxt_cfg_valid;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: tracks register writes, predicts each taken pixel beat,
    // checks output beats in order, and drives random stall bursts.
    // ------------------------------------------------------------------------
    int unsigned stall_left = 0;
    int unsigned stall_calm = 0;

    always @(posedge i_clk) begin : check_proc
        logic [PIX_W-1:0] want;
        if (!i_rst_n) begin
            i_out_stall   <= 1'b0;
            pix_in_flight <= 0;
        end else begin
            if (i_cfg_valid && o_cfg_ready)
                apply_reg_write(i_cfg_index, i_cfg_data);
            if (i_in_valid && !o_in_stall)
                expected_pixels.push_back(shutter_pixel(i_pixel_in));
            if (o_out_valid && !i_out_stall) begin
                if (expected_pixels.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected output beat, expected none, actual %08h",
                             $time, o_pixel_out);
                end else begin
                    want = expected_pixels.pop_front();
                    if (o_pixel_out !== want) begin
                        err_cnt++;
                        $display("%0t: pixel_out mismatch, expected %08h, actual %08h",
                                 $time, want, o_pixel_out);
                    end
                end
            end
            pix_in_flight <= expected_pixels.size();

            // random stall bursts, with calm stretches between
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (!tail && stall_calm == 0 && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 15) - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
                if (stall_calm > 0)
                    stall_calm--;
                else if ($urandom_range(0, 99) == 0)
                    stall_calm = $urandom_range(20, 80);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus build
    // ------------------------------------------------------------------------
    task automatic push_pixel(input logic [PIX_W-1:0] p);
        t_op op;
        op.kind = OP_PIXEL;
        op.idx  = '0;
        op.data = '0;
        op.pix  = p;
        stim_q.push_back(op);
    endtask

    task automatic push_reg(input logic [CFG_IDX_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] data);
        t_op op;
        op.kind = OP_REG;
        op.idx  = idx;
        op.data = data;
        op.pix  = '0;
        stim_q.push_back(op);
    endtask

    initial begin : main_proc
        int unsigned           rand_pix;
        int unsigned           dly_eff;
        int unsigned           fp_eff;
        int unsigned           frames;
        int unsigned           n;
        logic [CFG_DATA_W-1:0] dly_data;
        logic [CFG_DATA_W-1:0] fp_data;
        logic [CFG_DATA_W-1:0] mode_data;

        // -- directed --------------------------------------------------------
        // reset defaults: smooth, delay 1, 4096-pixel frame
        push_pixel(32'h0000_0000);
        push_pixel(32'hFFFF_FFFF);
        push_pixel(32'hA5A5_A5A5);
        // frame size 0 acts as 1: every pixel ends a frame, ring fills up
        push_reg(REG_FRAME, 13'h0000);
        push_pixel(32'hFFFF_FFFF);
        push_pixel(32'h0000_0000);
        // delay low bits 0 -> 1, same as now: counters must keep going
        push_reg(REG_DELAY, 13'h0020);
        push_pixel(32'h1234_5678);
        push_pixel(32'h8080_8080);
        push_pixel(32'h7F7F_7F7F);
        // simple mode, delay 1: copy, then G, B, R overwrites
        push_reg(REG_MODE, 13'h1FFF);
        push_pixel(32'h1122_3344);
        push_pixel(32'hFFFF_FFFF);
        push_pixel(32'h0000_0000);
        push_pixel(32'hA5A5_A5A5);
        push_pixel(32'h5A5A_5A5A);
        // unused index, then oversized delay and frame clamp to the maximum
        push_reg(REG_UNUSED, 13'h1FFF);
        push_reg(REG_DELAY, 13'h001F);
        push_reg(REG_FRAME, 13'h1FFF);
        push_pixel(32'hDEAD_BEEF);
        push_pixel(32'h0F0F_0F0F);
        push_pixel(32'hF0F0_F0F0);
        // simple mode, delay 2: rotation holds each channel two frames
        push_reg(REG_DELAY, 13'h0002);
        push_reg(REG_FRAME, 13'h0001);
        for (int k = 0; k < 6; k++)
            push_pixel($urandom());

        // -- random phases of whole frame sequences --------------------------
        rand_pix = 0;
        while (rand_pix < RAND_PIX) begin
            case ($urandom_range(0, 9))
                0:       dly_data = 13'd0;
                1:       dly_data = 13'd16;
                2:       dly_data = 13'd17;
                3:       dly_data = 13'($urandom_range(0, 8191));
                default: dly_data = 13'($urandom_range(1, 4));
            endcase
            case ($urandom_range(0, 11))
                0:       fp_data = 13'd0;
                1:       fp_data = 13'($urandom_range(0, 8191));
                2:       fp_data = 13'd4096;
                default: fp_data = 13'($urandom_range(1, 6));
            endcase
            mode_data = 13'($urandom_range(0, 8191));

            dly_eff = 32'(dly_data[DELAY_W-1:0]);
            if (dly_eff < 1) dly_eff = 1;
            if (dly_eff > N_DLY) dly_eff = N_DLY;
            fp_eff = 32'(fp_data);
            if (fp_eff < 1) fp_eff = 1;
            if (fp_eff > N_PIX) fp_eff = N_PIX;

            // registers in a random order; sometimes an extra or unused write
            case ($urandom_range(0, 2))
                0: begin
                    push_reg(REG_DELAY, dly_data);
                    push_reg(REG_MODE, mode_data);
                    push_reg(REG_FRAME, fp_data);
                end
                1: begin
                    push_reg(REG_FRAME, fp_data);
                    push_reg(REG_DELAY, dly_data);
                    push_reg(REG_MODE, mode_data);
                end
                default: begin
                    push_reg(REG_MODE, mode_data);
                    push_reg(REG_FRAME, fp_data);
                    push_reg(REG_DELAY, dly_data);
                end
            endcase
            if ($urandom_range(0, 5) == 0)
                push_reg(REG_UNUSED, 13'($urandom_range(0, 8191)));

            // up to enough frames to fill the ring or cycle the channel rotation
            if (mode_data[0])
                frames = $urandom_range(1, 3 * dly_eff + 3);
            else
                frames = $urandom_range(1, 2 * dly_eff + 3);
            if (fp_eff <= 8)
                n = fp_eff * frames + $urandom_range(0, fp_eff - 1);
            else
                n = $urandom_range(1, 24);
            // keep the total close to the budget
            if (n > RAND_PIX - rand_pix)
                n = RAND_PIX - rand_pix;
            for (int k = 0; k < n; k++)
                push_pixel($urandom());
            rand_pix += n;

            // same-value rewrite mid-sequence, then more beats
            if ($urandom_range(0, 3) == 0) begin
                push_reg(REG_FRAME, fp_data);
                n = $urandom_range(1, 12);
                for (int k = 0; k < n; k++)
                    push_pixel($urandom());
                rand_pix += n;
            end
        end

        // -- reset, run, drain -----------------------------------------------
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(posedge i_clk);
        while (!(drv_done && pix_in_flight == 0))
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        #1;

        if (expected_pixels.size() != 0) begin
            err_cnt++;
            $display("%0t: %0d expected beats never arrived, next expected %08h",
                     $time, expected_pixels.size(), expected_pixels[0]);
        end
        if (err_cnt == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Hard stop, far beyond the slowest correct run.
    initial begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

### harris_shutter_rgb_split_core.f
design/hsrgb_pkg.sv
design/hsrgb_ram.sv
design/hsrgb_seq.sv
design/harris_shutter_rgb_split_core.sv
tb/sv/tb_top.sv
